// ===== hdl/clsr_pkg.sv =====
// clsr_pkg: shared constants and types for the combined lcg shuffle generator
// no dependencies; used by the top level, clsr_modmul and clsr_slot_div
package clsr_pkg;

	// moduli of the two multiplicative generators
	localparam logic [31:0] MOD1 = 32'd2147483563;
	localparam logic [31:0] MOD2 = 32'd2147483399;

	// multipliers
	localparam logic [15:0] MUL1 = 16'd40014;
	localparam logic [15:0] MUL2 = 16'd40692;

	// 2^31 folded back into each modulus: 2^31 = FOLDx (mod MODx)
	localparam logic [15:0] FOLD1 = 16'(33'h1_0000_0000 / 2 - 33'(MOD1));
	localparam logic [15:0] FOLD2 = 16'(33'h1_0000_0000 / 2 - 33'(MOD2));

	// reset value of the second generator
	localparam logic [30:0] SEED2_INIT = 31'd123456789;

	// bus widths
	localparam int IN_W  = 32;
	localparam int OUT_W = 64;

	typedef enum logic {
		GEN_FIRST,
		GEN_SECOND
	} gen_sel_t;

	// request to the shared modular multiplier
	typedef struct packed {
		logic        start;
		gen_sel_t    sel;
		logic [30:0] operand;
	} mm_req_t;

	// response from the shared modular multiplier
	typedef struct packed {
		logic        done;
		logic [30:0] value;
	} mm_rsp_t;

endpackage

// ===== hdl/combined_lcg_shuffle_rng_top.sv =====
// combined_lcg_shuffle_rng_top: top level of the combined lcg shuffle generator
// depends on clsr_pkg, clsr_modmul, clsr_slot_div, clsr_table
//
// Random generator of the two-generator shuffle kind: two multiplicative
// congruential generators (moduli 2147483563 and 2147483399) feed a shuffle
// table of TABLE_ENTRIES entries. Each input item either draws with the held
// seed (tuser = 0) or loads tdata as a signed seed first (tuser = 1). A seed
// of zero or less (also a held seed of zero, as after reset) re-initializes:
// the seed is made positive, the second generator takes it, and
// TABLE_ENTRIES + 8 generator steps fill the table. Every item gives one
// result item holding the integer output (1..2147483562) and the updated seed.
// One generator step is one pass through the shared modular multiplier;
// a re-initializing draw runs the warm-up steps ahead of the draw. The
// input is not ready while an item is in work; a finished result waits in
// the output register and the next item can be accepted meanwhile.
module combined_lcg_shuffle_rng_top #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [clsr_pkg::IN_W-1:0]  s_axis_tdata,  // [31:0] seed_value
	input  logic [0:0]                 s_axis_tuser,  // [0] opcode
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [clsr_pkg::OUT_W-1:0] m_axis_tdata   // [30:0] random_value, [61:31] seed_out
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 8);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REINIT,
		ST_GEN1,
		ST_GEN2,
		ST_SLOT,
		ST_FINISH
	} state_t;

	state_t            state_q;
	clsr_pkg::mm_req_t mm_req_q;
	logic              div_start_q;
	logic [CW-1:0]     cnt_q;
	logic [30:0]       first_gen_q;
	logic [30:0]       second_gen_q;
	logic [30:0]       last_output_q;
	logic              out_valid_q;
	logic [30:0]       rand_q;
	logic [30:0]       seed_out_q;

	clsr_pkg::mm_rsp_t mm_rsp;
	logic              div_busy;
	logic [AW-1:0]     slot;

	logic              tbl_wr_en;
	logic [AW-1:0]     tbl_wr_addr;
	logic [30:0]       tbl_wr_data;
	logic              tbl_rd_en;
	logic [30:0]       tbl_rd_data;

	logic              in_accept;
	logic              out_free;
	logic [31:0]       seed;
	logic              seed_nonpos;
	logic [30:0]       seed_abs;
	logic [32:0]       diff;
	logic [32:0]       diff_wrap;
	logic [30:0]       outv;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	// seed selection: loaded seed is signed, held seed is always non-negative
	always_comb begin
		seed        = s_axis_tuser[0] ? s_axis_tdata : {1'b0, first_gen_q};
		seed_nonpos = seed[31] || (seed == '0);
		if (seed == '0) begin
			seed_abs = 31'd1;
		end else if (seed == 32'h8000_0000) begin
			// most negative seed saturates
			seed_abs = 31'h7FFF_FFFF;
		end else begin
			seed_abs = 31'(-seed);
		end
	end

	// output combine: slot value minus second generator, wrapped to 1..MOD1-1
	assign diff      = {2'b00, tbl_rd_data} - {2'b00, second_gen_q};
	assign diff_wrap = diff + 33'(clsr_pkg::MOD1 - 1);
	assign outv      = ($signed(diff) < 33'sd1) ? diff_wrap[30:0] : diff[30:0];

	// table write: warm-up fill, or refill of the used slot
	always_comb begin
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = slot;
		tbl_wr_data = first_gen_q;
		if (state_q == ST_REINIT) begin
			tbl_wr_en   = mm_rsp.done && (cnt_q < CW'(TABLE_ENTRIES));
			tbl_wr_addr = cnt_q[AW-1:0];
			tbl_wr_data = mm_rsp.value;
		end else if (state_q == ST_FINISH) begin
			tbl_wr_en = 1'b1;
		end
	end

	assign tbl_rd_en = (state_q == ST_SLOT) && !div_busy && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mm_req_q      <= '0;
			div_start_q   <= 1'b0;
			cnt_q         <= '0;
			first_gen_q   <= '0;
			second_gen_q  <= clsr_pkg::SEED2_INIT;
			last_output_q <= '0;
			out_valid_q   <= 1'b0;
			rand_q        <= '0;
			seed_out_q    <= '0;
		end else begin
			mm_req_q.start <= 1'b0;
			div_start_q    <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						mm_req_q.start <= 1'b1;
						mm_req_q.sel   <= clsr_pkg::GEN_FIRST;
						if (seed_nonpos) begin
							// re-initialize: warm-up walk from the positive seed
							mm_req_q.operand <= seed_abs;
							second_gen_q     <= seed_abs;
							cnt_q            <= CW'(TABLE_ENTRIES + 7);
							state_q          <= ST_REINIT;
						end else begin
							mm_req_q.operand <= seed[30:0];
							first_gen_q      <= seed[30:0];
							div_start_q      <= 1'b1;
							state_q          <= ST_GEN1;
						end
					end
				end
				ST_REINIT: begin
					if (mm_rsp.done) begin
						mm_req_q.start   <= 1'b1;
						mm_req_q.sel     <= clsr_pkg::GEN_FIRST;
						mm_req_q.operand <= mm_rsp.value;
						if (cnt_q == '0) begin
							// last warm-up value is also table entry zero
							first_gen_q   <= mm_rsp.value;
							last_output_q <= mm_rsp.value;
							div_start_q   <= 1'b1;
							state_q       <= ST_GEN1;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				ST_GEN1: begin
					if (mm_rsp.done) begin
						first_gen_q      <= mm_rsp.value;
						mm_req_q.start   <= 1'b1;
						mm_req_q.sel     <= clsr_pkg::GEN_SECOND;
						mm_req_q.operand <= second_gen_q;
						state_q          <= ST_GEN2;
					end
				end
				ST_GEN2: begin
					if (mm_rsp.done) begin
						second_gen_q <= mm_rsp.value;
						state_q      <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					// read the slot once the divider is done and the output is free
					if (!div_busy && out_free) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					last_output_q <= outv;
					rand_q        <= outv;
					seed_out_q    <= first_gen_q;
					out_valid_q   <= 1'b1;
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	clsr_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req_q),
		.rsp    (mm_rsp)
	);

	clsr_slot_div #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_slot_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (last_output_q),
		.busy     (div_busy),
		.slot     (slot)
	);

	clsr_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_en   (tbl_rd_en),
		.rd_addr (slot),
		.rd_data (tbl_rd_data)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(clsr_pkg::OUT_W - 62){1'b0}}, seed_out_q, rand_q};

	// multiplier results only arrive while a step is expected
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == ST_REINIT || state_q == ST_GEN1 || state_q == ST_GEN2))
		else $error("modmul result outside a generator step");

	// a new result only comes out of the finish step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish step");

	// the slot index is settled when the table entry is consumed
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !div_busy)
		else $error("slot divider still busy at finish");

	// the combined output never wraps to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[30:0] != '0))
		else $error("random value of zero");

endmodule

// ===== hdl/clsr_modmul.sv =====
// clsr_modmul: shared modular multiplier, one generator step (a * x) mod m
// in a multiply, a fold and a reduce step using one 31x16 multiplier; depends on clsr_pkg
module clsr_modmul (
	input  logic             clk,
	input  logic             arst_n,
	input  clsr_pkg::mm_req_t req,
	output clsr_pkg::mm_rsp_t rsp
);

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_FOLD,
		MM_RED
	} mm_state_t;

	mm_state_t          state_q;
	clsr_pkg::gen_sel_t sel_q;
	logic [46:0]        prod_q;
	logic [30:0]        lo_q;
	logic [30:0]        value_q;
	logic               done_q;

	logic [30:0] op_a;
	logic [15:0] op_b;
	logic [46:0] prod;
	logic [31:0] sum;
	logic [31:0] modv;
	logic [31:0] red;

	// operand select for the one multiplier
	always_comb begin
		if (state_q == MM_FOLD) begin
			op_a = {15'd0, prod_q[46:31]};
			op_b = (sel_q == clsr_pkg::GEN_FIRST) ? clsr_pkg::FOLD1 : clsr_pkg::FOLD2;
		end else begin
			op_a = req.operand;
			op_b = (req.sel == clsr_pkg::GEN_FIRST) ? clsr_pkg::MUL1 : clsr_pkg::MUL2;
		end
	end

	assign prod = {16'd0, op_a} * {31'd0, op_b};

	// lo + hi * fold stays below twice the modulus
	assign modv = (sel_q == clsr_pkg::GEN_FIRST) ? clsr_pkg::MOD1 : clsr_pkg::MOD2;
	assign sum  = {1'b0, lo_q} + prod_q[31:0];
	assign red  = (sum >= modv) ? (sum - modv) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			sel_q   <= clsr_pkg::GEN_FIRST;
			prod_q  <= '0;
			lo_q    <= '0;
			value_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MM_IDLE: begin
					if (req.start) begin
						sel_q   <= req.sel;
						prod_q  <= prod;
						state_q <= MM_FOLD;
					end
				end
				MM_FOLD: begin
					lo_q    <= prod_q[30:0];
					prod_q  <= prod;
					state_q <= MM_RED;
				end
				MM_RED: begin
					value_q <= red[30:0];
					done_q  <= 1'b1;
					state_q <= MM_IDLE;
				end
				default: begin
					state_q <= MM_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

// ===== hdl/clsr_slot_div.sv =====
// clsr_slot_div: table slot from the last output, divided by a constant
// reciprocal estimate then one correcting compare; depends on clsr_pkg
module clsr_slot_div #(
	parameter int TABLE_ENTRIES = 32,
	localparam int AW = $clog2(TABLE_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [30:0]   dividend,
	output logic          busy,
	output logic [AW-1:0] slot
);

	localparam logic [30:0] SLOT_DIV = 31'(1 + (clsr_pkg::MOD1 - 1) / TABLE_ENTRIES);
	// divisor is at least 2^23, so 2^39 / divisor fits 17 bits and the
	// estimate from the top 16 dividend bits is low by at most one
	localparam int          RSH   = 24;
	localparam logic [16:0] RECIP = 17'(40'h80_0000_0000 / 40'(SLOT_DIV));
	localparam int QW = AW + 1;
	localparam int DW = 31 + QW;

	logic          busy_q;
	logic [30:0]   num_q;
	logic [QW-1:0] est_q;
	logic [AW-1:0] slot_q;

	logic [32:0]   prod;
	logic [QW-1:0] est_inc;
	logic [DW-1:0] bound;
	logic [QW-1:0] quo;

	// quotient estimate, never above the true quotient
	assign prod    = {17'd0, dividend[30:15]} * {16'd0, RECIP};
	// bump the estimate when the next multiple still fits
	assign est_inc = est_q + QW'(1);
	assign bound   = {31'd0, est_inc} * {{QW{1'b0}}, SLOT_DIV};
	assign quo     = ({{QW{1'b0}}, num_q} >= bound) ? est_inc : est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			num_q  <= '0;
			est_q  <= '0;
			slot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			num_q  <= dividend;
			est_q  <= prod[RSH+QW-1:RSH];
		end else if (busy_q) begin
			busy_q <= 1'b0;
			// clamp to the last slot
			slot_q <= (quo >= QW'(TABLE_ENTRIES)) ? AW'(TABLE_ENTRIES - 1) : quo[AW-1:0];
		end
	end

	assign slot = slot_q;
	assign busy = busy_q;

endmodule

// ===== hdl/clsr_table.sv =====
// clsr_table: shuffle table memory, one write and one registered read port
// per-entry valid bits make unwritten entries read as zero; no dependencies
module clsr_table #(
	parameter int TABLE_ENTRIES = 32,
	localparam int AW = $clog2(TABLE_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [30:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [30:0]   rd_data
);

	logic [30:0]              mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [30:0]              rd_q;
	logic                     rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for combined_lcg_shuffle_rng_top, the shuffled two-generator rng
// depends on clsr_pkg and the hdl sources; holds its own model of the generator state and
// checks every result item against it under random idling and back-pressure
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 32;

	// generator constants, kept wide so products never overflow
	localparam longint MOD_A = 64'sd2147483563;
	localparam longint MOD_B = 64'sd2147483399;
	localparam longint MUL_A = 64'sd40014;
	localparam longint MUL_B = 64'sd40692;
	localparam longint QUO_A = 64'sd53668;
	localparam longint QUO_B = 64'sd52774;
	localparam longint REM_A = 64'sd12211;
	localparam longint REM_B = 64'sd3791;
	localparam logic [30:0] SECOND_RESET = 31'd123456789;
	localparam longint SLOT_DIV = 1 + (MOD_A - 1) / SLOTS;

	// worst case work for one item: warm-up steps plus the draw itself
	localparam int SETTLE_CYCLES = 4 * (SLOTS + 8) + 60;

	// seeds that sit on the edges of the seed handling
	localparam logic [31:0] SEED_MOST_NEG = 32'h8000_0000;
	localparam logic [31:0] SEED_MOST_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SEED_AT_MOD_A = 32'd2147483563;
	localparam logic [31:0] SEED_AT_MOD_B = 32'd2147483399;
	localparam logic [31:0] SEED_TOP_OUT  = 32'd2147483562;

	typedef enum logic [0:0] {
		OP_DRAW = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef struct {
		logic [30:0] random_value;
		logic [30:0] seed_out;
	} draw_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [clsr_pkg::IN_W-1:0] s_axis_tdata = '0;   // [31:0] seed_value
	logic [0:0] s_axis_tuser = '0;                   // [0] opcode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [clsr_pkg::OUT_W-1:0] m_axis_tdata;        // [30:0] random_value, [61:31] seed_out

	// model state of the generator
	logic [30:0] first_seed = '0;
	logic [30:0] second_seed = SECOND_RESET;
	logic [30:0] prev_draw = '0;
	logic [30:0] shuffle_slots [SLOTS] = '{default: '0};

	draw_t expected_draws [$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_request = 0;

	combined_lcg_shuffle_rng_top #(
		.TABLE_ENTRIES(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one multiplicative generator step, split so the product stays small (schrage)
	function automatic longint lcg_advance(input longint x, input longint mul,
		input longint quo, input longint rem, input longint modulus);
		longint k;
		longint v;
		k = x / quo;
		v = mul * (x - k * quo) - k * rem;
		if (v < 0) v += modulus;
		return v;
	endfunction

	// advance the model by one input item and return the result it must produce
	function automatic draw_t predict_draw(input op_t op, input logic [31:0] seed_in);
		longint seed;
		longint x;
		longint y;
		longint diff;
		int slot;
		int i;
		draw_t r;
		if (op == OP_LOAD) seed = longint'($signed(seed_in));
		else seed = longint'(first_seed);

		if (seed <= 0) begin
			// zero becomes one, negatives are negated, the most negative saturates
			if (seed == 0) seed = 1;
			else if (seed == -64'sd2147483648) seed = 64'sd2147483647;
			else seed = -seed;
			second_seed = 31'(seed);
			x = seed;
			// eight warm-up steps, then the table fills from the top slot down
			for (i = SLOTS + 7; i >= 0; i--) begin
				x = lcg_advance(x, MUL_A, QUO_A, REM_A, MOD_A);
				if (i < SLOTS) shuffle_slots[i] = 31'(x);
			end
			first_seed = 31'(x);
			prev_draw = shuffle_slots[0];
		end else begin
			first_seed = 31'(seed);
		end

		x = lcg_advance(longint'(first_seed), MUL_A, QUO_A, REM_A, MOD_A);
		y = lcg_advance(longint'(second_seed), MUL_B, QUO_B, REM_B, MOD_B);
		first_seed = 31'(x);
		second_seed = 31'(y);

		// previous output picks the slot, clamped although it never overflows
		slot = int'(longint'(prev_draw) / SLOT_DIV);
		if (slot >= SLOTS) slot = SLOTS - 1;

		diff = longint'(shuffle_slots[slot]) - y;
		shuffle_slots[slot] = first_seed;
		if (diff < 1) diff += MOD_A - 1;
		prev_draw = 31'(diff);

		r.random_value = prev_draw;
		r.seed_out = first_seed;
		return r;
	endfunction

	// offer one item, with random gaps ahead of it, and log its expectation once taken
	task automatic send_item(input op_t op, input logic [31:0] seed_in);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= seed_in;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_draws.push_back(predict_draw(op, seed_in));
	endtask

	// mostly held-seed draws, some fresh positive seeds, some re-initializing ones
	task automatic send_random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			send_item(OP_DRAW, $urandom());
		end else if (pick < 87) begin
			send_item(OP_LOAD, {1'b0, 31'($urandom())});
		end else if (pick < 96) begin
			send_item(OP_LOAD, $urandom() | SEED_MOST_NEG);
		end else begin
			case ($urandom_range(0, 3))
				0: send_item(OP_LOAD, '0);
				1: send_item(OP_LOAD, SEED_MOST_NEG);
				2: send_item(OP_LOAD, SEED_AT_MOD_A);
				default: send_item(OP_LOAD, SEED_MOST_POS);
			endcase
		end
	endtask

	// stop offering and wait until every expected result item has come back
	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		while (expected_draws.size() != 0) @(posedge clk);
	endtask

	// draws on the all-zero table left by reset, before any re-initialization
	task automatic test_cold_table();
		send_item(OP_LOAD, 32'd5);
		send_item(OP_DRAW, 32'd0);
		send_item(OP_DRAW, 32'd0);
	endtask

	// zero, negative, saturating and large positive seeds
	task automatic test_seed_extremes();
		send_item(OP_LOAD, 32'd0);
		send_item(OP_LOAD, 32'd1);
		send_item(OP_LOAD, 32'hFFFF_FFFF);
		send_item(OP_LOAD, SEED_MOST_NEG);
		send_item(OP_LOAD, SEED_MOST_NEG + 32'd1);
		send_item(OP_LOAD, SEED_MOST_POS);
		send_item(OP_LOAD, SEED_TOP_OUT);
		send_item(OP_LOAD, SEED_AT_MOD_B);
	endtask

	// a seed equal to the first modulus steps to zero, so the next held draw re-initializes
	task automatic test_modulus_seed();
		send_item(OP_LOAD, SEED_AT_MOD_A);
		send_item(OP_DRAW, 32'd0);
		send_item(OP_DRAW, 32'd0);
	endtask

	// on a held-seed draw the data word must be ignored
	task automatic test_ignored_seed();
		send_item(OP_DRAW, 32'hFFFF_FFFF);
		send_item(OP_DRAW, SEED_MOST_NEG);
		send_item(OP_DRAW, 32'h5A5A_A5A5);
	endtask

	task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
		int n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < count; n++) send_random_item();
	endtask

	// receiver holds off for a long stretch while items keep coming, so the input stalls
	task automatic test_backpressure();
		int n;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 300;
		send_item(OP_LOAD, 32'hFFFF_0000);
		for (n = 0; n < 7; n++) send_item(OP_DRAW, $urandom());
	endtask

	// sender pauses until everything is back, then resumes on the held state
	task automatic test_drain_pause();
		int n;
		send_idle_pct = 0;
		recv_stall_pct = 30;
		for (n = 0; n < 5; n++) send_random_item();
		wait_results_done();
		for (n = 0; n < 5; n++) send_random_item();
	endtask

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// result checker: compare each accepted result item with the oldest expectation
	always @(posedge clk) begin
		draw_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (expected_draws.size() == 0) begin
				$display("%0t: unexpected result item, expected none, actual %h",
					$time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want = expected_draws.pop_front();
				if (m_axis_tdata[30:0] !== want.random_value) begin
					$display("%0t: random_value mismatch, expected %0d, actual %0d",
						$time, want.random_value, m_axis_tdata[30:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[61:31] !== want.seed_out) begin
					$display("%0t: seed_out mismatch, expected %0d, actual %0d",
						$time, want.seed_out, m_axis_tdata[61:31]);
					mismatch_count++;
				end
				if (m_axis_tdata[63:62] !== 2'b00) begin
					$display("%0t: tdata padding mismatch, expected 0, actual %b",
						$time, m_axis_tdata[63:62]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("combined_lcg_shuffle_rng_top verification failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cold_table();
		test_seed_extremes();
		test_modulus_seed();
		test_ignored_seed();

		test_random_phase(140, 0, 0);
		test_backpressure();
		test_random_phase(140, 62, 0);
		test_drain_pause();
		test_random_phase(140, 0, 62);
		test_random_phase(140, 20, 20);

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_draws.size() == 0) begin
			$display("combined_lcg_shuffle_rng_top verification clean");
		end else begin
			$display("combined_lcg_shuffle_rng_top verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/clsr_pkg.sv
hdl/clsr_modmul.sv
hdl/clsr_slot_div.sv
hdl/clsr_table.sv
hdl/combined_lcg_shuffle_rng_top.sv
test/tb_top.sv
